[src/bfsa_pkg.sv]
// Shared constants, codes and state type for the best-fit segment allocator.
package bfsa_pkg;

    localparam int ADDR_BITS = 32;
    localparam int LEN_W     = 32;
    localparam int VAL_W     = 38;
    localparam int STAT_W    = 3;
    localparam int REQ_W     = 2;
    localparam int OWN_W     = 7;
    localparam int QIDX_W    = 4;
    localparam int CFG_W     = 33;

    localparam int DEF_FREE_SEGMENTS    = 64;
    localparam int DEF_OWNERS           = 128;
    localparam int DEF_QUEUES_PER_OWNER = 16;

    localparam logic [ADDR_BITS:0] POOL_MAX = {1'b1, {ADDR_BITS{1'b0}}};

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_BAD   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_ALLOC = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FREED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_SEND  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BAD   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT,
        S_DISP,
        S_ASCAN,
        S_AUPD,
        S_FQ,
        S_FSCAN,
        S_FUPD,
        S_FSHIFT,
        S_SEND
    } bfsa_state_t;

endpackage

[src/best_fit_segment_allocator.sv]
// Best-fit segment allocator: request sequencer, free table and queue tables.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  request  | start / busy              | req_type, owner, length, queue_index
//  result   | done (one-cycle strobe)   | status, value
//  config   | cfg_valid / cfg_ready     | cfg_data (pool_size)
//
// Allocate and free each sweep the free-segment RAM, one entry per cycle; a free
// then shifts each later queue of the owner down one place, unless the free table
// is full; send walks the owner's queues. A request can also be rejected at
// dispatch, before any sweep.
// No clearing pass after reset: entry 0 and the valid bits come out of reset directly.
// A new request is taken in the cycle its predecessor's done is shown; results
// cannot be stalled.
module best_fit_segment_allocator #(
    parameter int FREE_SEGMENTS    = bfsa_pkg::DEF_FREE_SEGMENTS,
    parameter int OWNERS           = bfsa_pkg::DEF_OWNERS,
    parameter int QUEUES_PER_OWNER = bfsa_pkg::DEF_QUEUES_PER_OWNER
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bfsa_pkg::REQ_W-1:0]    req_type,
    input  logic [bfsa_pkg::OWN_W-1:0]    owner,
    input  logic [bfsa_pkg::LEN_W-1:0]    length,
    input  logic [bfsa_pkg::QIDX_W-1:0]   queue_index,
    output logic                          done,
    output logic [bfsa_pkg::STAT_W-1:0]   status,
    output logic [bfsa_pkg::VAL_W-1:0]    value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfsa_pkg::CFG_W-1:0]    cfg_data
);
    import bfsa_pkg::*;

    localparam int AW     = ADDR_BITS;
    localparam int FW     = $clog2(FREE_SEGMENTS);
    localparam int FCW    = $clog2(FREE_SEGMENTS + 1);
    localparam int OWW    = OWNERS > 1 ? $clog2(OWNERS) : 1;
    localparam int QSLOTS = OWNERS * QUEUES_PER_OWNER;
    localparam int SW     = QSLOTS > 1 ? $clog2(QSLOTS) : 1;
    localparam int CW     = $clog2(QUEUES_PER_OWNER + 1);
    localparam int FEW    = 2 * AW + 1;
    localparam int QEW    = AW + 2 * LEN_W;

    localparam logic [FCW-1:0] FS_C    = FCW'(FREE_SEGMENTS);
    localparam logic [CW-1:0]  QPO_C   = CW'(QUEUES_PER_OWNER);
    localparam logic [10:0]    OWN_LIM = 11'(OWNERS);

    bfsa_state_t state_reg, state_next;

    logic [REQ_W-1:0]  req_reg;
    logic [OWN_W-1:0]  owner_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [QIDX_W-1:0] qidx_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SW-1:0]     slot_base_reg;
    logic [FCW-1:0]    scan_reg;

    logic          p_vld_reg, p_fv_reg, p_e0_reg;
    logic [FW-1:0] p_idx_reg;

    logic [FREE_SEGMENTS-1:0] fv_reg;
    logic                     e0_init_reg;
    logic [OWNERS-1:0]        cv_reg;

    logic          best_found_reg;
    logic [FW-1:0] best_idx_reg;
    logic [AW:0]   best_len_reg;
    logic [AW-1:0] best_start_reg;

    logic [AW-1:0]    q_base_reg;
    logic [LEN_W-1:0] q_len_reg;
    logic             right_found_reg, left_found_reg, empty_found_reg;
    logic [FW-1:0]    right_idx_reg, left_idx_reg, empty_idx_reg;
    logic [AW:0]      right_len_reg, left_len_reg;
    logic [AW-1:0]    left_start_reg;

    logic [CW-1:0]    k_reg, q_k_reg;
    logic             q_vld_reg;
    logic [VAL_W-1:0] sum_reg;

    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic [VAL_W-1:0]  value_reg;

    // memory ports
    logic           fw_en, qw_en, cw_en;
    logic [FW-1:0]  fw_addr, fr_addr;
    logic [FEW-1:0] fw_data, fq;
    logic [SW-1:0]  qw_addr, qr_addr;
    logic [QEW-1:0] qw_data, qq;
    logic [OWW-1:0] own_idx;
    logic [CW-1:0]  cw_data, cq;

    logic              fin;
    logic [STAT_W-1:0] fin_status;
    logic [VAL_W-1:0]  fin_value;

    logic              cfg_fire;
    logic [AW:0]       cfg_size;
    logic              own_ok;
    logic [CW-1:0]     cnt_now;
    logic [AW-1:0]     fd_start;
    logic [AW:0]       fd_len;
    logic [AW:0]       q_end;
    logic [AW+1:0]     left_end;
    logic [AW+1:0]     tot;
    logic              more;
    logic [AW-1:0]     qq_base;
    logic [LEN_W-1:0]  qq_len, qq_wp, wp_new;
    logic [LEN_W:0]    wp_inc;
    logic              free_any;
    logic [FW-1:0]     free_target;

    bfsa_ram #(.WIDTH(FEW), .DEPTH(FREE_SEGMENTS)) u_free_ram (
        .clk(clk), .we(fw_en), .waddr(fw_addr), .wdata(fw_data),
        .raddr(fr_addr), .rdata(fq)
    );

    bfsa_ram #(.WIDTH(QEW), .DEPTH(QSLOTS)) u_queue_ram (
        .clk(clk), .we(qw_en), .waddr(qw_addr), .wdata(qw_data),
        .raddr(qr_addr), .rdata(qq)
    );

    bfsa_ram #(.WIDTH(CW), .DEPTH(OWNERS)) u_count_ram (
        .clk(clk), .we(cw_en), .waddr(own_idx), .wdata(cw_data),
        .raddr(own_idx), .rdata(cq)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_size  = (cfg_data > POOL_MAX) ? POOL_MAX : cfg_data;
    assign done      = done_reg;
    assign status    = status_reg;
    assign value     = value_reg;

    assign own_idx  = OWW'(owner_reg);
    assign own_ok   = {4'b0, owner_reg} < OWN_LIM;
    assign cnt_now  = cv_reg[own_idx] ? cq : '0;
    // entry 0 holds the reset pool until first written
    assign fd_start = p_e0_reg ? '0 : fq[FEW-1:AW+1];
    assign fd_len   = p_e0_reg ? POOL_MAX : fq[AW:0];
    assign q_end    = {1'b0, q_base_reg} + {1'b0, q_len_reg};
    assign left_end = {2'b0, fd_start} + {1'b0, fd_len};
    assign tot      = {2'b0, q_len_reg} + (right_found_reg ? {1'b0, right_len_reg} : '0);
    assign more     = k_reg < cnt_reg;

    assign qq_base = qq[QEW-1:2*LEN_W];
    assign qq_len  = qq[2*LEN_W-1:LEN_W];
    assign qq_wp   = qq[LEN_W-1:0];
    assign wp_inc  = {1'b0, qq_wp} + (LEN_W+1)'(1);
    assign wp_new  = (wp_inc >= {1'b0, qq_len}) ? '0 : wp_inc[LEN_W-1:0];

    assign free_any    = left_found_reg || right_found_reg || empty_found_reg;
    assign free_target = right_found_reg ? right_idx_reg : empty_idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                state_next = S_DISP;
            end
            S_DISP:
            begin
                if (fin)
                begin
                    state_next = S_IDLE;
                end
                else if (req_reg == REQ_ALLOC)
                begin
                    state_next = S_ASCAN;
                end
                else if (req_reg == REQ_SEND)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    state_next = S_FQ;
                end
            end
            S_ASCAN:
            begin
                if (scan_reg == FS_C)
                begin
                    state_next = S_AUPD;
                end
            end
            S_AUPD:
            begin
                state_next = S_IDLE;
            end
            S_FQ:
            begin
                state_next = S_FSCAN;
            end
            S_FSCAN:
            begin
                if (scan_reg == FS_C)
                begin
                    state_next = S_FUPD;
                end
            end
            S_FUPD:
            begin
                state_next = fin ? S_IDLE : S_FSHIFT;
            end
            S_FSHIFT, S_SEND:
            begin
                if (fin)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls and result
    always_comb
    begin
        fw_en      = 1'b0;
        fw_addr    = best_idx_reg;
        fw_data    = {best_start_reg + len_reg, best_len_reg - {1'b0, len_reg}};
        fr_addr    = scan_reg[FW-1:0];
        qw_en      = 1'b0;
        qw_addr    = slot_base_reg + SW'(cnt_reg);
        qw_data    = {best_start_reg, len_reg, {LEN_W{1'b0}}};
        qr_addr    = slot_base_reg + SW'(k_reg);
        cw_en      = 1'b0;
        cw_data    = cnt_reg + CW'(1);
        fin        = 1'b0;
        fin_status = STAT_BAD;
        fin_value  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    fw_en   = 1'b1;
                    fw_addr = '0;
                    fw_data = {{AW{1'b0}}, cfg_size};
                end
            end
            S_DISP:
            begin
                qr_addr = slot_base_reg + SW'(qidx_reg);
                if (!own_ok || req_reg == REQ_BAD)
                begin
                    fin = 1'b1;
                end
                else if (req_reg == REQ_ALLOC)
                begin
                    if (len_reg == '0)
                    begin
                        fin = 1'b1;
                    end
                    else if (cnt_now >= QPO_C)
                    begin
                        fin        = 1'b1;
                        fin_status = STAT_FULL;
                    end
                end
                else if (req_reg == REQ_FREE)
                begin
                    if ({{CW{1'b0}}, qidx_reg} >= {{QIDX_W{1'b0}}, cnt_now})
                    begin
                        fin = 1'b1;
                    end
                end
            end
            S_AUPD:
            begin
                fin = 1'b1;
                if (!best_found_reg)
                begin
                    fin_status = STAT_NOFIT;
                end
                else
                begin
                    fin_status = STAT_ALLOC;
                    fin_value  = VAL_W'(best_start_reg);
                    fw_en      = best_len_reg > {1'b0, len_reg};
                    qw_en      = 1'b1;
                    cw_en      = 1'b1;
                end
            end
            S_FUPD:
            begin
                if (!free_any)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_FULL;
                end
                else
                begin
                    fw_en = 1'b1;
                    if (left_found_reg)
                    begin
                        fw_addr = left_idx_reg;
                        fw_data = {left_start_reg, (AW+1)'({1'b0, left_len_reg} + tot)};
                    end
                    else
                    begin
                        fw_addr = free_target;
                        fw_data = {q_base_reg, (AW+1)'(tot)};
                    end
                end
            end
            S_FSHIFT:
            begin
                qw_en   = q_vld_reg;
                qw_addr = slot_base_reg + SW'(q_k_reg) - SW'(1);
                qw_data = qq;
                if (!more)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_FREED;
                    cw_en      = 1'b1;
                    cw_data    = cnt_reg - CW'(1);
                end
            end
            S_SEND:
            begin
                qw_en   = q_vld_reg;
                qw_addr = slot_base_reg + SW'(q_k_reg);
                qw_data = {qq_base, qq_len, wp_new};
                if (!more && !q_vld_reg)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_SEND;
                    fin_value  = sum_reg;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fv_reg      <= FREE_SEGMENTS'(1);
            e0_init_reg <= 1'b1;
            cv_reg      <= '0;
            p_vld_reg   <= 1'b0;
            q_vld_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (fw_en && fw_addr == '0)
            begin
                e0_init_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && cfg_fire)
            begin
                fv_reg <= FREE_SEGMENTS'(cfg_size != '0);
                cv_reg <= '0;
            end
            if (state_reg == S_AUPD && best_found_reg)
            begin
                cv_reg[own_idx] <= 1'b1;
                if (!(best_len_reg > {1'b0, len_reg}))
                begin
                    fv_reg[best_idx_reg] <= 1'b0;
                end
            end
            if (state_reg == S_FUPD && free_any)
            begin
                // without a left neighbour the right entry is reused in place
                if (left_found_reg)
                begin
                    if (right_found_reg)
                    begin
                        fv_reg[right_idx_reg] <= 1'b0;
                    end
                end
                else
                begin
                    fv_reg[free_target] <= 1'b1;
                end
            end
            if ((state_reg == S_ASCAN || state_reg == S_FSCAN) && scan_reg != FS_C)
            begin
                p_vld_reg <= 1'b1;
            end
            else
            begin
                p_vld_reg <= 1'b0;
            end
            if ((state_reg == S_FSHIFT || state_reg == S_SEND) && more)
            begin
                q_vld_reg <= 1'b1;
            end
            else
            begin
                q_vld_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg   <= req_type;
            owner_reg <= owner;
            len_reg   <= length;
            qidx_reg  <= queue_index;
        end
        if (state_reg == S_CNT)
        begin
            slot_base_reg <= SW'(own_idx * QUEUES_PER_OWNER);
        end
        if (state_reg == S_DISP)
        begin
            cnt_reg         <= cnt_now;
            scan_reg        <= '0;
            best_found_reg  <= 1'b0;
            right_found_reg <= 1'b0;
            left_found_reg  <= 1'b0;
            empty_found_reg <= 1'b0;
            k_reg           <= '0;
            sum_reg         <= '0;
        end
        if ((state_reg == S_ASCAN || state_reg == S_FSCAN) && scan_reg != FS_C)
        begin
            p_idx_reg <= scan_reg[FW-1:0];
            p_fv_reg  <= fv_reg[scan_reg[FW-1:0]];
            p_e0_reg  <= e0_init_reg && scan_reg == '0;
            scan_reg  <= scan_reg + FCW'(1);
        end
        if (state_reg == S_ASCAN && p_vld_reg && p_fv_reg && fd_len >= {1'b0, len_reg})
        begin
            if (!best_found_reg || fd_len < best_len_reg ||
                (fd_len == best_len_reg && fd_start < best_start_reg))
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= p_idx_reg;
                best_len_reg   <= fd_len;
                best_start_reg <= fd_start;
            end
        end
        if (state_reg == S_FQ)
        begin
            q_base_reg <= qq_base;
            q_len_reg  <= qq_len;
        end
        if (state_reg == S_FSCAN && p_vld_reg)
        begin
            if (!p_fv_reg)
            begin
                if (!empty_found_reg)
                begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= p_idx_reg;
                end
            end
            else
            begin
                if (!right_found_reg && {1'b0, fd_start} == q_end)
                begin
                    right_found_reg <= 1'b1;
                    right_idx_reg   <= p_idx_reg;
                    right_len_reg   <= fd_len;
                end
                if (!left_found_reg && left_end == {2'b0, q_base_reg})
                begin
                    left_found_reg <= 1'b1;
                    left_idx_reg   <= p_idx_reg;
                    left_start_reg <= fd_start;
                    left_len_reg   <= fd_len;
                end
            end
        end
        if (state_reg == S_FUPD)
        begin
            // later queues move down one place: read k, write k-1
            k_reg <= CW'(qidx_reg) + CW'(1);
        end
        if ((state_reg == S_FSHIFT || state_reg == S_SEND) && more)
        begin
            q_k_reg <= k_reg;
            k_reg   <= k_reg + CW'(1);
        end
        if (state_reg == S_SEND && q_vld_reg)
        begin
            sum_reg <= sum_reg + VAL_W'(qq_base) + VAL_W'(qq_wp);
        end
        if (fin)
        begin
            status_reg <= fin_status;
            value_reg  <= fin_value;
        end
    end

    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a request in flight");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_ALLOC && status != STAT_SEND) |-> value == '0)
        else $error("non-zero value on a status without one");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule

[src/bfsa_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[bench/best_fit_segment_allocator_tb.sv]
// Self-checking testbench for the best-fit segment allocator.
module best_fit_segment_allocator_tb;
    import bfsa_pkg::*;

    localparam int NSEG = DEF_FREE_SEGMENTS;
    localparam int NOWN = DEF_OWNERS;
    localparam int NQ   = DEF_QUEUES_PER_OWNER;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
    } answer_t;

    // Mirror of the allocator: free table, per-owner queue lists, expected answers.
    class alloc_scoreboard;
        logic [32:0] seg_start [NSEG];
        logic [32:0] seg_len   [NSEG];
        bit          seg_used  [NSEG];
        logic [31:0] q_base [NOWN][NQ];
        logic [31:0] q_len  [NOWN][NQ];
        logic [31:0] q_wptr [NOWN][NQ];
        int          q_cnt  [NOWN];
        answer_t     pending[$];
        int          errors;
        int          checked;
        int          status_seen [8];

        function void reload(logic [32:0] size);
            logic [32:0] sz;
            sz = (size > POOL_MAX) ? POOL_MAX : size;
            for (int i = 0; i < NSEG; i++)
            begin
                seg_start[i] = 0;
                seg_len[i] = 0;
                seg_used[i] = 0;
            end
            for (int o = 0; o < NOWN; o++)
                q_cnt[o] = 0;
            seg_len[0] = sz;
            seg_used[0] = (sz != 0);
        endfunction

        function answer_t allocate(int own, logic [31:0] len);
            answer_t a;
            int best;
            a = '{STAT_BAD, '0};
            best = -1;
            if (len == 0)
                return a;
            if (q_cnt[own] >= NQ)
            begin
                a.status = STAT_FULL;
                return a;
            end
            for (int i = 0; i < NSEG; i++)
            begin
                if (!seg_used[i] || seg_len[i] < {1'b0, len})
                    continue;
                if (best < 0 || seg_len[i] < seg_len[best] ||
                    (seg_len[i] == seg_len[best] && seg_start[i] < seg_start[best]))
                    best = i;
            end
            if (best < 0)
            begin
                a.status = STAT_NOFIT;
                return a;
            end
            a = '{STAT_ALLOC, VAL_W'(seg_start[best])};
            q_base[own][q_cnt[own]] = seg_start[best][31:0];
            q_len[own][q_cnt[own]] = len;
            q_wptr[own][q_cnt[own]] = 0;
            q_cnt[own]++;
            if (seg_len[best] > {1'b0, len})
            begin
                seg_start[best] += len;
                seg_len[best] -= len;
            end
            else
            begin
                seg_used[best] = 0;
                seg_start[best] = 0;
                seg_len[best] = 0;
            end
            return a;
        endfunction

        function answer_t release_queue(int own, int idx);
            answer_t a;
            logic [33:0] base, len;
            int lft, rgt, emp;
            a = '{STAT_BAD, '0};
            lft = -1;
            rgt = -1;
            emp = -1;
            if (idx >= q_cnt[own])
                return a;
            base = q_base[own][idx];
            len = q_len[own][idx];
            for (int i = 0; i < NSEG; i++)
            begin
                if (!seg_used[i])
                begin
                    if (emp < 0)
                        emp = i;
                    continue;
                end
                if (rgt < 0 && {1'b0, seg_start[i]} == base + len)
                    rgt = i;
                if (lft < 0 && {1'b0, seg_start[i]} + seg_len[i] == base)
                    lft = i;
            end
            if (lft < 0 && rgt < 0 && emp < 0)
            begin
                a.status = STAT_FULL;
                return a;
            end
            if (rgt >= 0)
            begin
                len += seg_len[rgt];
                seg_used[rgt] = 0;
                seg_start[rgt] = 0;
                seg_len[rgt] = 0;
                emp = rgt;
            end
            if (lft >= 0)
                seg_len[lft] += len[32:0];
            else
            begin
                seg_used[emp] = 1;
                seg_start[emp] = base[32:0];
                seg_len[emp] = len[32:0];
            end
            for (int k = idx; k + 1 < q_cnt[own]; k++)
            begin
                q_base[own][k] = q_base[own][k+1];
                q_len[own][k] = q_len[own][k+1];
                q_wptr[own][k] = q_wptr[own][k+1];
            end
            q_cnt[own]--;
            a.status = STAT_FREED;
            return a;
        endfunction

        function answer_t send_sum(int own);
            logic [VAL_W-1:0] sum;
            sum = 0;
            for (int k = 0; k < q_cnt[own]; k++)
            begin
                sum += VAL_W'(q_base[own][k]) + VAL_W'(q_wptr[own][k]);
                if ({1'b0, q_wptr[own][k]} + 33'd1 >= {1'b0, q_len[own][k]})
                    q_wptr[own][k] = 0;
                else
                    q_wptr[own][k]++;
            end
            return '{STAT_SEND, sum};
        endfunction

        function void note_request(logic [1:0] rt, logic [6:0] own, logic [31:0] len,
                                   logic [3:0] idx);
            answer_t a;
            if (rt == REQ_ALLOC)
                a = allocate(own, len);
            else if (rt == REQ_SEND)
                a = send_sum(own);
            else if (rt == REQ_FREE)
                a = release_queue(own, idx);
            else
                a = '{STAT_BAD, '0};
            pending.insert(pending.size(), a);
        endfunction

        function void check_answer(logic [STAT_W-1:0] st, logic [VAL_W-1:0] val);
            answer_t e;
            checked++;
            if (st <= STAT_FULL)
                status_seen[st]++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d value=%0d", $time, st, val);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (val !== e.value)
            begin
                $display("%0t: value expected %0d actual %0d", $time, e.value, val);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [REQ_W-1:0]   req_type = '0;
    logic [OWN_W-1:0]   owner = '0;
    logic [LEN_W-1:0]   length = '0;
    logic [QIDX_W-1:0]  queue_index = '0;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   value;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;

    alloc_scoreboard sb;
    int     idle_pct;
    int     sent;
    longint cycles;

    best_fit_segment_allocator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .owner(owner), .length(length),
        .queue_index(queue_index), .done(done), .status(status), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && done)
            sb.check_answer(status, value);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // start stays up after an accept until the next negedge that drives it;
    // the block is busy in that cycle, so the beat is not taken twice
    task automatic send_request(logic [1:0] rt, logic [6:0] own, logic [31:0] len,
                                logic [3:0] idx);
        bit accepted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        req_type <= rt;
        owner <= own;
        length <= len;
        queue_index <= idx;
        accepted = 0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = !busy;
        end
        sb.note_request(rt, own, len, idx);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (NSEG + NQ + 20)
            @(negedge clk);
    endtask

    // Only written while idle; reloads the pool in the mirror too.
    task automatic write_pool(logic [32:0] size);
        drain();
        cfg_valid <= 1;
        cfg_data <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.reload(size);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Small owner set and modest lengths keep lists and the free table busy.
    task automatic random_request(logic [32:0] pool);
        int r;
        logic [31:0] len;
        logic [6:0] own;
        r = $urandom_range(99);
        own = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(5));
        case ($urandom_range(5))
            0: len = $urandom;
            1: len = $urandom_range(4);
            default: len = (pool > 64) ? $urandom_range(1, int'(pool[31:0] / 24) + 1)
                                       : $urandom_range(1, 8);
        endcase
        if (r < 45)
            send_request(REQ_ALLOC, own, len, 4'($urandom));
        else if (r < 85)
            send_request(REQ_FREE, own, 32'($urandom),
                         4'($urandom_range(sb.q_cnt[own] > 0 ? sb.q_cnt[own] : 15)));
        else if (r < 97)
            send_request(REQ_SEND, own, 32'($urandom), 4'($urandom));
        else
            send_request(REQ_BAD, own, 32'($urandom), 4'($urandom));
    endtask

    initial
    begin
        logic [32:0] pools [5];
        int phase_pct [4];
        sb = new();
        sb.reload(POOL_MAX);
        pools = '{33'd1000, 33'd4096, POOL_MAX, 33'h1_FFFF_FFFF, 33'd200};
        phase_pct = '{0, 50, 0, 13};
        repeat (9)
            @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: reset pool of 2^32
        send_request(REQ_ALLOC, 0, 32'hFFFF_FFFF, 0);
        send_request(REQ_ALLOC, 0, 32'd1, 0);
        send_request(REQ_ALLOC, 0, 32'd1, 0);
        send_request(REQ_SEND, 0, 0, 0);
        send_request(REQ_SEND, 0, 0, 0);
        send_request(REQ_SEND, 7'd127, 32'hFFFF_FFFF, 4'hF);
        send_request(REQ_ALLOC, 1, 0, 0);
        send_request(REQ_FREE, 0, 0, 4'hF);
        send_request(REQ_FREE, 0, 0, 0);
        send_request(REQ_FREE, 0, 0, 0);
        send_request(REQ_BAD, 7'd127, 32'hFFFF_FFFF, 4'hF);
        send_request(REQ_ALLOC, 7'd127, 32'd5, 0);
        for (int i = 0; i < 17; i++)
            send_request(REQ_ALLOC, 2, 32'd3, 0);
        send_request(REQ_SEND, 2, 0, 0);

        // zero pool: nothing fits
        write_pool(33'd0);
        send_request(REQ_ALLOC, 3, 32'd1, 0);
        send_request(REQ_SEND, 3, 0, 0);

        // fill the free table with holes, then a free with no neighbour
        write_pool(33'd300);
        idle_pct = 0;
        for (int i = 0; i < 130; i++)
            send_request(REQ_ALLOC, 7'(10 + i / 16), 32'd2, 0);
        for (int o = 10; o < 18; o++)
            for (int k = 0; k < 8; k++)
                send_request(REQ_FREE, 7'(o), 0, 4'(k));
        for (int i = 0; i < 30; i++)
            random_request(33'd300);

        // random phases under several pool sizes and idling rates
        for (int p = 0; p < 5; p++)
        begin
            write_pool(pools[p]);
            for (int ph = 0; ph < 4; ph++)
            begin
                idle_pct = phase_pct[ph];
                for (int i = 0; i < 55; i++)
                    random_request(pools[p]);
                if (ph == 1)
                    drain();
            end
        end

        drain();
        $display("Sent %0d requests, checked %0d results: alloc %0d nofit %0d freed %0d",
                 sent, sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        $display("send %0d bad %0d full %0d over six pool sizes",
                 sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[sim.f]
src/bfsa_pkg.sv
src/bfsa_ram.sv
src/best_fit_segment_allocator.sv
bench/best_fit_segment_allocator_tb.sv
